// ===== rtl/cmr_pkg.sv =====
package cmr_pkg;
  localparam int BufferDepth = 8192;
  localparam int AddrW = 13;
  localparam int LenW = 14;
  localparam int InitPayload = 57;
  localparam int ContPayload = 59;
  localparam logic [13:0] MaxLenReset = 14'd7609;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_PENDING = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_BAD_CHANNEL = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_BUSY = 3'd4,
    ST_BAD_SEQ = 3'd5,
    ST_TIMEOUT = 3'd6,
    ST_NO_EVENT = 3'd7
  } status_t;
endpackage

// ===== rtl/cmr_payload_ram.sv =====
// Payload store: one write port, one registered read port
module cmr_payload_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [cmr_pkg::AddrW-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic [cmr_pkg::AddrW-1:0] rd_addr,
  output logic [7:0]                rd_data
);
  logic [7:0] mem [cmr_pkg::BufferDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/ctaphid_message_reassembler.sv =====
// CTAP HID message reassembler. Hold start with an operation until busy is
// low; exactly one result follows, shown for one cycle with out_valid, and
// the receiver cannot stall it. A report shifts its payload one byte per cycle
// into the payload memory through the byte shift register and the memory
// write port, so its result comes later the more bytes it carries: at most
// 59 for a continuation and 57 for an init. A rejected report, a cancel and
// a timeout go from decode straight to the result; a payload read passes
// through S_READ and S_READ2 first. busy drops in the cycle that shows the
// result, so the next transaction can be taken at the edge that ends it.
module ctaphid_message_reassembler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_report_word_0,
  input  logic [63:0] in_report_word_1,
  input  logic [63:0] in_report_word_2,
  input  logic [63:0] in_report_word_3,
  input  logic [63:0] in_report_word_4,
  input  logic [63:0] in_report_word_5,
  input  logic [63:0] in_report_word_6,
  input  logic [63:0] in_report_word_7,
  input  logic [31:0] in_cancel_channel,
  input  logic [12:0] in_read_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_max_message_len,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_msg_channel,
  output logic [6:0]  out_msg_command,
  output logic [13:0] out_msg_length,
  output logic [7:0]  out_read_byte
);
  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_COPY, S_READ, S_READ2, S_DONE} state_t;

  state_t state_r;
  logic [13:0] max_len_r;
  logic        assembling_r;
  logic [31:0] chan_r;
  logic [6:0]  cmd_r;
  logic [13:0] exp_len_r;
  logic [13:0] rcv_r;
  logic [7:0]  seq_r;
  logic [1:0]  op_r;
  logic [31:0] cancel_r;
  logic [12:0] ridx_r;
  logic [511:0] sh_r;       // report bytes, byte 0 at the bottom
  logic [5:0]  cnt_r;       // bytes still to write
  logic [12:0] waddr_r;
  logic [2:0]  st_r;
  logic [7:0]  rbyte_r;

  logic [7:0] rd_data;
  logic       wr_en;

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_en = (state_r == S_COPY) && (cnt_r != 6'd0);

  cmr_payload_ram u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(waddr_r), .wr_data(sh_r[7:0]),
    .rd_addr(ridx_r), .rd_data(rd_data)
  );

  // Report header decode
  logic [31:0] cid;
  logic [7:0]  b4;
  logic [13:0] len_lim;
  logic [15:0] rlen;
  logic [13:0] remain;
  assign cid = sh_r[31:0];
  assign b4 = sh_r[39:32];
  assign rlen = {sh_r[47:40], sh_r[55:48]};
  assign len_lim = (max_len_r > 14'(cmr_pkg::BufferDepth)) ? 14'(cmr_pkg::BufferDepth)
                                                           : max_len_r;
  assign remain = exp_len_r - rcv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_len_r <= cmr_pkg::MaxLenReset;
      assembling_r <= 1'b0;
      chan_r <= '0; cmd_r <= '0; exp_len_r <= '0; rcv_r <= '0; seq_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid) max_len_r <= cfg_max_message_len;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r <= in_operation;
            cancel_r <= in_cancel_channel;
            ridx_r <= in_read_index;
            sh_r <= {in_report_word_7, in_report_word_6, in_report_word_5,
                     in_report_word_4, in_report_word_3, in_report_word_2,
                     in_report_word_1, in_report_word_0};
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          st_r <= cmr_pkg::ST_NO_EVENT;
          state_r <= S_DONE;
          cnt_r <= '0;
          case (cmr_pkg::op_t'(op_r))
            cmr_pkg::OP_CANCEL: begin
              if (assembling_r && chan_r == cancel_r) assembling_r <= 1'b0;
            end
            cmr_pkg::OP_TIMEOUT: begin
              if (assembling_r) begin
                assembling_r <= 1'b0;
                st_r <= cmr_pkg::ST_TIMEOUT;
              end
            end
            cmr_pkg::OP_READ: state_r <= S_READ;
            default: begin
              if (cid == 32'd0) begin
                st_r <= cmr_pkg::ST_BAD_CHANNEL;
              end else if (b4[7]) begin
                if (rlen > {2'b0, len_lim}) begin
                  assembling_r <= 1'b0;
                  st_r <= cmr_pkg::ST_BAD_LENGTH;
                end else if (assembling_r && chan_r != cid) begin
                  st_r <= cmr_pkg::ST_BUSY;
                end else begin
                  chan_r <= cid;
                  cmd_r <= b4[6:0];
                  exp_len_r <= rlen[13:0];
                  seq_r <= '0;
                  waddr_r <= '0;
                  sh_r <= sh_r >> 56;
                  if (rlen[13:0] > 14'(cmr_pkg::InitPayload)) begin
                    cnt_r <= 6'(cmr_pkg::InitPayload);
                    rcv_r <= 14'(cmr_pkg::InitPayload);
                    assembling_r <= 1'b1;
                    st_r <= cmr_pkg::ST_PENDING;
                  end else begin
                    cnt_r <= rlen[5:0];
                    rcv_r <= rlen[13:0];
                    assembling_r <= 1'b0;
                    st_r <= cmr_pkg::ST_COMPLETE;
                  end
                  state_r <= S_COPY;
                end
              end else begin
                if (!assembling_r || chan_r != cid) begin
                  st_r <= cmr_pkg::ST_BAD_SEQ;
                end else if (b4 != seq_r) begin
                  assembling_r <= 1'b0;
                  st_r <= cmr_pkg::ST_BAD_SEQ;
                end else begin
                  sh_r <= sh_r >> 40;
                  waddr_r <= rcv_r[12:0];
                  seq_r <= seq_r + 8'd1;
                  if (remain > 14'(cmr_pkg::ContPayload)) begin
                    cnt_r <= 6'(cmr_pkg::ContPayload);
                    rcv_r <= rcv_r + 14'(cmr_pkg::ContPayload);
                  end else begin
                    cnt_r <= remain[5:0];
                    rcv_r <= exp_len_r;
                  end
                  if (seq_r == 8'd127) begin
                    assembling_r <= 1'b0;
                    st_r <= cmr_pkg::ST_BAD_LENGTH;
                  end else if (remain > 14'(cmr_pkg::ContPayload)) begin
                    st_r <= cmr_pkg::ST_PENDING;
                  end else begin
                    assembling_r <= 1'b0;
                    st_r <= cmr_pkg::ST_COMPLETE;
                  end
                  state_r <= S_COPY;
                end
              end
            end
          endcase
        end
        // one payload byte per cycle into the store
        S_COPY: begin
          if (cnt_r == 6'd0) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r - 6'd1;
            waddr_r <= waddr_r + 13'd1;
            sh_r <= sh_r >> 8;
          end
        end
        S_READ: state_r <= S_READ2;
        S_READ2: begin
          rbyte_r <= rd_data;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_status <= st_r;
          out_read_byte <= (op_r == cmr_pkg::OP_READ) ? rbyte_r : 8'd0;
          if (st_r == cmr_pkg::ST_COMPLETE) begin
            out_msg_channel <= chan_r;
            out_msg_command <= cmd_r;
            out_msg_length <= exp_len_r;
          end else begin
            out_msg_channel <= '0;
            out_msg_command <= '0;
            out_msg_length <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/cmr_checker.sv =====
// Port-level checks
module cmr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic [13:0] out_msg_length,
  input logic [7:0] out_read_byte
);
  // a new transaction makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start not taken");
  // result strobe is a single cycle
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  // a result closes the transaction
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy after result");
  // length only shown on completion
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cmr_pkg::ST_COMPLETE |-> out_msg_length == 14'd0)
    else $error("stray length");
  // a payload byte only comes back with a no-event status
  a_rbyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_byte != 8'd0 |-> out_status == cmr_pkg::ST_NO_EVENT)
    else $error("stray read byte");
endmodule

bind ctaphid_message_reassembler cmr_checker u_cmr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_msg_length(out_msg_length),
  .out_read_byte(out_read_byte)
);
